[design/pmkr_pkg.sv]
// ----------------------------------------------------------------------------
// pmkr_pkg: shared types and constants for the point-mass rollout
// Sequencer state codes, the controller command word, register indexes,
// reset values and the CORDIC constant tables.
// ----------------------------------------------------------------------------
package pmkr_pkg;

  // Sequencer steps; the divider and CORDIC steps loop over their iterations
  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_U, ST_MUL_W, ST_MUL_A, ST_DIV_INIT, ST_DIV, ST_UPD,
    ST_MUL_PL, ST_MUL_PH, ST_MUL_TL, ST_MUL_TH, ST_MUL_RP, ST_MUL_RT,
    ST_MUL_DS, ST_DS_WB, ST_CORDIC, ST_QUAD, ST_MUL_CC, ST_MUL_SC,
    ST_MUL_XH, ST_MUL_XL, ST_MUL_YH, ST_MUL_YL, ST_MUL_ZH, ST_MUL_ZL,
    ST_SUM_Z, ST_UPD_Z, ST_DONE
  } pmkr_state_e;

  typedef struct packed {
    pmkr_state_e op;
    logic        load_in;
    logic        load_out;
    logic [5:0]  iter;
  } pmkr_cmd_t;

  // Register indexes on the configuration port
  localparam logic [7:0] REG_STEP_COUNT = 8'd0;
  localparam logic [7:0] REG_TIME_STEP  = 8'd1;
  localparam logic [7:0] REG_MIN_SPEED  = 8'd2;
  localparam logic [7:0] REG_MAX_SPEED  = 8'd3;

  localparam logic [7:0]  RST_STEP_COUNT = 8'd10;
  localparam logic [16:0] RST_TIME_STEP  = 17'd3277;
  localparam logic [30:0] RST_MIN_SPEED  = 31'd655360;
  localparam logic [30:0] RST_MAX_SPEED  = 31'd1310720;

  // Status codes
  localparam logic [1:0] LIM_NONE = 2'd0;
  localparam logic [1:0] LIM_LOW  = 2'd1;
  localparam logic [1:0] LIM_HIGH = 2'd2;

  localparam int DIV_BITS     = 49;
  localparam int CORDIC_ITERS = 30;
  localparam int DS_LO_BITS   = 24;

  localparam logic [63:0] INV2PI_Q64      = 64'h28BE60DB9391054A;
  localparam logic [30:0] PIO2_Q30        = 31'd1686629713;
  localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

  // Arctangent of 2^-i in Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd843314857;
      5'd1: r = 30'd497837830;
      5'd2: r = 30'd263043837;
      5'd3: r = 30'd133525159;
      5'd4: r = 30'd67021687;
      5'd5: r = 30'd33543516;
      5'd6: r = 30'd16775851;
      5'd7: r = 30'd8388437;
      5'd8: r = 30'd4194283;
      5'd9: r = 30'd2097149;
      default: r = 30'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

[design/pmkr_ctrl.sv]
// ----------------------------------------------------------------------------
// pmkr_ctrl: sequencer for the rollout datapath
// Walks each Euler step through its multiply, divide and CORDIC phases and
// handles the input and output handshakes.
// ----------------------------------------------------------------------------
module pmkr_ctrl import pmkr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic [7:0] step_count_i,
  output pmkr_cmd_t  cmd_o
);

  pmkr_state_e state_q, state_d;
  logic [7:0]  step_q;
  logic [5:0]  cnt_q;
  logic        out_valid_q;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (step_count_i == 8'd0) ? ST_DONE : ST_MUL_U;
        end
      end
      ST_MUL_U:    state_d = ST_MUL_W;
      ST_MUL_W:    state_d = ST_MUL_A;
      ST_MUL_A:    state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == 6'(DIV_BITS - 1)) state_d = ST_UPD;
      end
      ST_UPD:      state_d = ST_MUL_PL;
      ST_MUL_PL:   state_d = ST_MUL_PH;
      ST_MUL_PH:   state_d = ST_MUL_TL;
      ST_MUL_TL:   state_d = ST_MUL_TH;
      ST_MUL_TH:   state_d = ST_MUL_RP;
      ST_MUL_RP:   state_d = ST_MUL_RT;
      ST_MUL_RT:   state_d = ST_MUL_DS;
      ST_MUL_DS:   state_d = ST_DS_WB;
      ST_DS_WB:    state_d = ST_CORDIC;
      ST_CORDIC: begin
        if (cnt_q == 6'(CORDIC_ITERS - 1)) state_d = ST_QUAD;
      end
      ST_QUAD:     state_d = ST_MUL_CC;
      ST_MUL_CC:   state_d = ST_MUL_SC;
      ST_MUL_SC:   state_d = ST_MUL_XH;
      ST_MUL_XH:   state_d = ST_MUL_XL;
      ST_MUL_XL:   state_d = ST_MUL_YH;
      ST_MUL_YH:   state_d = ST_MUL_YL;
      ST_MUL_YL:   state_d = ST_MUL_ZH;
      ST_MUL_ZH:   state_d = ST_MUL_ZL;
      ST_MUL_ZL:   state_d = ST_SUM_Z;
      ST_SUM_Z:    state_d = ST_UPD_Z;
      ST_UPD_Z:    state_d = (step_q == 8'd1) ? ST_DONE : ST_MUL_U;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o.op       = state_q;
    cmd_o.iter     = cnt_q;
    cmd_o.load_in  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.load_out = (state_q == ST_DONE) && out_free;
    in_stall_o     = (state_q != ST_IDLE);
    out_valid_o    = out_valid_q;
  end

  // State, loop counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 8'd0;
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) step_q <= step_count_i;
      else if (state_q == ST_UPD_Z) step_q <= step_q - 8'd1;
      if (state_q == ST_DIV || state_q == ST_CORDIC) begin
        cnt_q <= (state_d == state_q) ? cnt_q + 6'd1 : 6'd0;
      end else begin
        cnt_q <= 6'd0;
      end
      if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

endmodule

[design/pmkr_datapath.sv]
// ----------------------------------------------------------------------------
// pmkr_datapath: state registers, shared multiplier, divider and CORDIC
// One 33x33 signed multiplier with a registered product serves every
// product; a two-lane restoring divider and two CORDIC lanes run a bit or a
// rotation per cycle.
// ----------------------------------------------------------------------------
module pmkr_datapath import pmkr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  pmkr_cmd_t          cmd_i,
  input  logic [16:0]        time_step_i,
  input  logic [30:0]        speed_lo_i,
  input  logic [30:0]        speed_hi_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] heading_i,
  input  logic signed [31:0] pitch_i,
  input  logic signed [31:0] speed_i,
  input  logic signed [31:0] accel_i,
  input  logic signed [31:0] heading_rate_i,
  input  logic signed [31:0] pitch_rate_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  output logic signed [31:0] new_heading_o,
  output logic signed [31:0] new_pitch_o,
  output logic signed [31:0] new_speed_o,
  output logic [1:0]         limit_status_o
);

  localparam logic [63:0] PHASE_K = INV2PI_Q64 >> FRAC_BITS;

  function automatic logic signed [31:0] sat50(input logic signed [49:0] s);
    logic signed [31:0] r;
    if (s > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (s < -50'sd2147483648) r = 32'sh80000000;
    else r = s[31:0];
    return r;
  endfunction

  // Signed quotient from magnitude, with zero-divisor handling
  function automatic logic signed [31:0] quot(input logic [48:0] mag,
                                              input logic neg,
                                              input logic den_zero,
                                              input logic signed [48:0] num);
    logic signed [31:0] r;
    if (den_zero) begin
      if (num > 49'sd0) r = 32'sh7FFFFFFF;
      else if (num < 49'sd0) r = 32'sh80000000;
      else r = 32'sd0;
    end else if (neg) begin
      if (mag > 49'h0_8000_0000) r = 32'sh80000000;
      else r = -$signed(mag[31:0]);
    end else begin
      if (mag > 49'h0_7FFF_FFFF) r = 32'sh7FFFFFFF;
      else r = $signed(mag[31:0]);
    end
    return r;
  endfunction

  logic signed [31:0] x_q, y_q, z_q, p_q, t_q, v_q, a_q, u_q, w_q;
  logic [1:0]         stat_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [48:0] num_u_q, num_w_q, da_q;
  logic [48:0]        nmu_q, nmw_q, qu_q, qw_q;
  logic [31:0]        den_q;
  logic [31:0]        rem_u_q, rem_w_q;
  logic               neg_u_q, neg_w_q;
  logic [63:0]        acc_p_q, acc_t_q;
  logic [31:0]        phase_p_q, phase_t_q;
  logic signed [32:0] zp_q, zt_q;
  logic signed [33:0] xp_q, yp_q, xt_q, yt_q;
  logic signed [32:0] cp_q, sp_q, ct_q, st_q, cc_q, sc_q;
  logic signed [40:0] ds_q;
  logic signed [73:0] acc_q, sum_q;
  logic signed [73:0] prod_ext;
  logic signed [32:0] ds_hi, ds_lo;
  logic [32:0]        rn_u, rn_w;
  logic               ge_u, ge_w;
  logic signed [31:0] v_new;
  logic [29:0]        atan_i;
  logic signed [32:0] atan_s;

  assign prod_ext = 74'(prod_q);
  assign ds_hi    = 33'($signed(ds_q[40:DS_LO_BITS]));
  assign ds_lo    = {{(33 - DS_LO_BITS){1'b0}}, ds_q[DS_LO_BITS-1:0]};
  assign rn_u     = {rem_u_q, nmu_q[48]};
  assign rn_w     = {rem_w_q, nmw_q[48]};
  assign ge_u     = rn_u >= {1'b0, den_q};
  assign ge_w     = rn_w >= {1'b0, den_q};
  assign v_new    = sat50(50'(v_q) + 50'(da_q));
  assign atan_i   = atan_q30(cmd_i.iter[4:0]);
  assign atan_s   = $signed({3'b000, atan_i});

  // Select multiplier operands
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (cmd_i.op)
      ST_MUL_U:  begin mul_a = 33'(u_q); mul_b = $signed({16'd0, time_step_i}); end
      ST_MUL_W:  begin mul_a = 33'(w_q); mul_b = $signed({16'd0, time_step_i}); end
      ST_MUL_A:  begin mul_a = 33'(a_q); mul_b = $signed({16'd0, time_step_i}); end
      ST_MUL_DS: begin mul_a = 33'(v_q); mul_b = $signed({16'd0, time_step_i}); end
      ST_MUL_PL: begin mul_a = 33'(p_q); mul_b = $signed({1'b0, PHASE_K[31:0]}); end
      ST_MUL_PH: begin mul_a = 33'(p_q); mul_b = $signed({1'b0, PHASE_K[63:32]}); end
      ST_MUL_TL: begin mul_a = 33'(t_q); mul_b = $signed({1'b0, PHASE_K[31:0]}); end
      ST_MUL_TH: begin mul_a = 33'(t_q); mul_b = $signed({1'b0, PHASE_K[63:32]}); end
      ST_MUL_RP: begin
        mul_a = $signed({3'b000, phase_p_q[29:0]}); mul_b = $signed({2'b00, PIO2_Q30});
      end
      ST_MUL_RT: begin
        mul_a = $signed({3'b000, phase_t_q[29:0]}); mul_b = $signed({2'b00, PIO2_Q30});
      end
      ST_MUL_CC: begin mul_a = cp_q;  mul_b = ct_q; end
      ST_MUL_SC: begin mul_a = sp_q;  mul_b = ct_q; end
      ST_MUL_XH: begin mul_a = ds_hi; mul_b = cc_q; end
      ST_MUL_XL: begin mul_a = ds_lo; mul_b = cc_q; end
      ST_MUL_YH: begin mul_a = ds_hi; mul_b = sc_q; end
      ST_MUL_YL: begin mul_a = ds_lo; mul_b = sc_q; end
      ST_MUL_ZH: begin mul_a = ds_hi; mul_b = st_q; end
      ST_MUL_ZL: begin mul_a = ds_lo; mul_b = st_q; end
      default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
    endcase
  end

  // Shared multiplier and per-step write-back
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.load_in) begin
      x_q <= pos_x_i; y_q <= pos_y_i; z_q <= pos_z_i;
      p_q <= heading_i; t_q <= pitch_i; v_q <= speed_i;
      a_q <= accel_i; u_q <= heading_rate_i; w_q <= pitch_rate_i;
      stat_q <= LIM_NONE;
    end
    if (cmd_i.load_out) begin
      new_x_o <= x_q; new_y_o <= y_q; new_z_o <= z_q;
      new_heading_o <= p_q; new_pitch_o <= t_q; new_speed_o <= v_q;
      limit_status_o <= stat_q;
    end
    case (cmd_i.op)
      ST_MUL_W: num_u_q <= prod_q[48:0];
      ST_MUL_A: num_w_q <= prod_q[48:0];
      ST_DIV_INIT: begin
        da_q    <= 49'(prod_q >>> FRAC_BITS);
        nmu_q   <= num_u_q[48] ? 49'(-num_u_q) : num_u_q;
        nmw_q   <= num_w_q[48] ? 49'(-num_w_q) : num_w_q;
        neg_u_q <= num_u_q[48] ^ v_q[31];
        neg_w_q <= num_w_q[48] ^ v_q[31];
        den_q   <= v_q[31] ? 32'(-v_q) : v_q;
        rem_u_q <= 32'd0;
        rem_w_q <= 32'd0;
      end
      // One quotient bit per lane
      ST_DIV: begin
        rem_u_q <= ge_u ? 32'(rn_u - {1'b0, den_q}) : rn_u[31:0];
        rem_w_q <= ge_w ? 32'(rn_w - {1'b0, den_q}) : rn_w[31:0];
        qu_q    <= {qu_q[47:0], ge_u};
        qw_q    <= {qw_q[47:0], ge_w};
        nmu_q   <= {nmu_q[47:0], 1'b0};
        nmw_q   <= {nmw_q[47:0], 1'b0};
      end
      // Advance angles and speed, check limits
      ST_UPD: begin
        p_q <= sat50(50'(p_q) + 50'(quot(qu_q, neg_u_q, den_q == 32'd0, num_u_q)));
        t_q <= sat50(50'(t_q) + 50'(quot(qw_q, neg_w_q, den_q == 32'd0, num_w_q)));
        v_q <= v_new;
        if (33'(v_new) < $signed({2'b00, speed_lo_i})) stat_q <= LIM_LOW;
        else if (33'(v_new) > $signed({2'b00, speed_hi_i})) stat_q <= LIM_HIGH;
      end
      ST_MUL_PH: acc_p_q   <= prod_q[63:0];
      ST_MUL_TL: phase_p_q <= acc_p_q[63:32] + prod_q[31:0];
      ST_MUL_TH: acc_t_q   <= prod_q[63:0];
      ST_MUL_RP: phase_t_q <= acc_t_q[63:32] + prod_q[31:0];
      ST_MUL_RT: zp_q      <= $signed(prod_q[62:30]);
      ST_MUL_DS: zt_q      <= $signed(prod_q[62:30]);
      ST_DS_WB: begin
        ds_q <= 41'(prod_q >>> FRAC_BITS);
        xp_q <= $signed(CORDIC_GAIN_Q30); yp_q <= 34'sd0;
        xt_q <= $signed(CORDIC_GAIN_Q30); yt_q <= 34'sd0;
      end
      // One rotation per lane
      ST_CORDIC: begin
        if (zp_q >= 33'sd0) begin
          xp_q <= xp_q - (yp_q >>> cmd_i.iter); yp_q <= yp_q + (xp_q >>> cmd_i.iter);
          zp_q <= zp_q - atan_s;
        end else begin
          xp_q <= xp_q + (yp_q >>> cmd_i.iter); yp_q <= yp_q - (xp_q >>> cmd_i.iter);
          zp_q <= zp_q + atan_s;
        end
        if (zt_q >= 33'sd0) begin
          xt_q <= xt_q - (yt_q >>> cmd_i.iter); yt_q <= yt_q + (xt_q >>> cmd_i.iter);
          zt_q <= zt_q - atan_s;
        end else begin
          xt_q <= xt_q + (yt_q >>> cmd_i.iter); yt_q <= yt_q - (xt_q >>> cmd_i.iter);
          zt_q <= zt_q + atan_s;
        end
      end
      // Fold back into the quadrant
      ST_QUAD: begin
        case (phase_p_q[31:30])
          2'd0: begin cp_q <= 33'(xp_q);  sp_q <= 33'(yp_q);  end
          2'd1: begin cp_q <= 33'(-yp_q); sp_q <= 33'(xp_q);  end
          2'd2: begin cp_q <= 33'(-xp_q); sp_q <= 33'(-yp_q); end
          default: begin cp_q <= 33'(yp_q); sp_q <= 33'(-xp_q); end
        endcase
        case (phase_t_q[31:30])
          2'd0: begin ct_q <= 33'(xt_q);  st_q <= 33'(yt_q);  end
          2'd1: begin ct_q <= 33'(-yt_q); st_q <= 33'(xt_q);  end
          2'd2: begin ct_q <= 33'(-xt_q); st_q <= 33'(-yt_q); end
          default: begin ct_q <= 33'(yt_q); st_q <= 33'(-xt_q); end
        endcase
      end
      ST_MUL_SC: cc_q <= 33'(prod_q >>> 30);
      ST_MUL_XH: sc_q <= 33'(prod_q >>> 30);
      // Split products of ds, then advance the position
      ST_MUL_XL: acc_q <= prod_ext <<< DS_LO_BITS;
      ST_MUL_YH: sum_q <= acc_q + prod_ext;
      ST_MUL_YL: begin
        acc_q <= prod_ext <<< DS_LO_BITS;
        x_q   <= sat50(50'(x_q) + 50'($signed(sum_q[73:30])));
      end
      ST_MUL_ZH: sum_q <= acc_q + prod_ext;
      ST_MUL_ZL: begin
        acc_q <= prod_ext <<< DS_LO_BITS;
        y_q   <= sat50(50'(y_q) + 50'($signed(sum_q[73:30])));
      end
      ST_SUM_Z: sum_q <= acc_q + prod_ext;
      ST_UPD_Z: z_q   <= sat50(50'(z_q) + 50'($signed(sum_q[73:30])));
      default: ;
    endcase
  end

endmodule

[design/point_mass_kinematic_rollout.sv]
// ----------------------------------------------------------------------------
// point_mass_kinematic_rollout: forward Euler rollout of a 3D point mass
// Usage: a state and control word enters on in_valid_i/in_stall_o; the block
// runs step_count Euler steps and returns one result word on
// out_valid_o/out_stall_i. Registers are written on the cfg port (index 0
// step_count, 1 time_step, 2 lower speed limit, 3 upper speed limit); the user
// must write them only while idle, which the block itself does not enforce.
// The two-lane divider and the two-lane CORDIC dominate each step. One
// word is worked on at a time; the next is taken once the previous result
// sits in the output register. A stalled result holds in that register, and
// the block then waits in its final step until the register frees.
// Reset clears the sequencer and output valid and loads the register
// defaults (10 steps, dt 0.05, speed limits 10 and 20).
// ----------------------------------------------------------------------------
module point_mass_kinematic_rollout import pmkr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] heading_i,
  input  logic signed [31:0] pitch_i,
  input  logic signed [31:0] speed_i,
  input  logic signed [31:0] accel_i,
  input  logic signed [31:0] heading_rate_i,
  input  logic signed [31:0] pitch_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  output logic signed [31:0] new_heading_o,
  output logic signed [31:0] new_pitch_o,
  output logic signed [31:0] new_speed_o,
  output logic [1:0]         limit_status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [7:0]  step_count_q;
  logic [16:0] time_step_q;
  logic [30:0] speed_lo_q, speed_hi_q;
  pmkr_cmd_t   cmd;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= RST_STEP_COUNT;
      time_step_q  <= RST_TIME_STEP;
      speed_lo_q   <= RST_MIN_SPEED;
      speed_hi_q   <= RST_MAX_SPEED;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_STEP_COUNT: step_count_q <= cfg_data_i[7:0];
        REG_TIME_STEP:  time_step_q  <= cfg_data_i[16:0];
        REG_MIN_SPEED:  speed_lo_q   <= cfg_data_i[30:0];
        REG_MAX_SPEED:  speed_hi_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  pmkr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .step_count_i (step_count_q),
    .cmd_o        (cmd)
  );

  pmkr_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .time_step_i    (time_step_q),
    .speed_lo_i     (speed_lo_q),
    .speed_hi_i     (speed_hi_q),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .heading_i      (heading_i),
    .pitch_i        (pitch_i),
    .speed_i        (speed_i),
    .accel_i        (accel_i),
    .heading_rate_i (heading_rate_i),
    .pitch_rate_i   (pitch_rate_i),
    .new_x_o        (new_x_o),
    .new_y_o        (new_y_o),
    .new_z_o        (new_z_o),
    .new_heading_o  (new_heading_o),
    .new_pitch_o    (new_pitch_o),
    .new_speed_o    (new_speed_o),
    .limit_status_o (limit_status_o)
  );

endmodule

[dv/tb_point_mass_kinematic_rollout.sv]
// ----------------------------------------------------------------------------
// tb_point_mass_kinematic_rollout: self-checking bench for the Euler rollout
// Drives state and control words with random gaps, predicts each final state
// with a bit-exact rollout model, and compares every result word in order.
// ----------------------------------------------------------------------------
module tb_point_mass_kinematic_rollout;
  import pmkr_pkg::*;

  localparam int FRAC = 16;
  localparam logic [63:0] PHASE_K = INV2PI_Q64 >> FRAC;

  typedef struct packed {
    logic signed [31:0] px, py, pz, hd, pt, sp, ac, hr, pr;
  } state_word_t;

  typedef struct packed {
    logic signed [31:0] x, y, z, hd, pt, sp;
    logic [1:0]         lim;
  } rollout_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic in_taken = 1'b0;
  state_word_t drv = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] new_x_o, new_y_o, new_z_o, new_heading_o, new_pitch_o, new_speed_o;
  logic [1:0] limit_status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  state_word_t pending_words[$];
  rollout_t    expected_states[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Shadow register file
  logic [7:0]  steps_q = RST_STEP_COUNT;
  logic [16:0] dt_q = RST_TIME_STEP;
  logic [30:0] vmin_q = RST_MIN_SPEED;
  logic [30:0] vmax_q = RST_MAX_SPEED;

  point_mass_kinematic_rollout #(.FRAC_BITS(FRAC)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pos_x_i(drv.px), .pos_y_i(drv.py), .pos_z_i(drv.pz), .heading_i(drv.hd),
    .pitch_i(drv.pt), .speed_i(drv.sp), .accel_i(drv.ac),
    .heading_rate_i(drv.hr), .pitch_rate_i(drv.pr),
    .out_valid_o, .out_stall_i, .new_x_o, .new_y_o, .new_z_o, .new_heading_o,
    .new_pitch_o, .new_speed_o, .limit_status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sat_quot(longint num, longint den);
    if (den == 0) begin
      if (num > 0) return 64'sd2147483647;
      if (num < 0) return -64'sd2147483648;
      return 0;
    end
    return clamp32(num / den);
  endfunction

  // Cosine and sine in Q30 by quadrant fold and CORDIC rotation
  task automatic sincos_q30(input longint ang, output longint c, output longint s);
    logic [63:0] prod;
    logic [31:0] ph;
    longint r, z, cx, cy, rot, dx, dy;
    prod = 64'(ang) * PHASE_K;
    ph = prod[63:32];
    r = longint'(ph[29:0]);
    z = (r * longint'(PIO2_Q30)) >>> 30;
    cx = longint'(CORDIC_GAIN_Q30);
    cy = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      rot = longint'(atan_q30(5'(i)));
      dx = floor_sh(cy, i);
      dy = floor_sh(cx, i);
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= rot;
      end else begin
        cx += dx; cy -= dy; z += rot;
      end
    end
    case (ph[31:30])
      2'd0: begin c = cx; s = cy; end
      2'd1: begin c = -cy; s = cx; end
      2'd2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
  endtask

  // Run the configured number of Euler steps on one word
  task automatic roll_out(input state_word_t w, output rollout_t r);
    longint x, y, z, hd, pt, v, dt, cp, sp, ct, st, ds, cc, sc;
    logic [1:0] lim;
    x = w.px; y = w.py; z = w.pz; hd = w.hd; pt = w.pt; v = w.sp;
    dt = longint'(dt_q);
    lim = LIM_NONE;
    for (int n = 0; n < steps_q; n++) begin
      hd = clamp32(hd + sat_quot(longint'(w.hr) * dt, v));
      pt = clamp32(pt + sat_quot(longint'(w.pr) * dt, v));
      v = clamp32(v + floor_sh(longint'(w.ac) * dt, FRAC));
      if (v < longint'(vmin_q)) lim = LIM_LOW;
      else if (v > longint'(vmax_q)) lim = LIM_HIGH;
      sincos_q30(hd, cp, sp);
      sincos_q30(pt, ct, st);
      ds = floor_sh(v * dt, FRAC);
      cc = floor_sh(cp * ct, 30);
      sc = floor_sh(sp * ct, 30);
      x = clamp32(x + floor_sh(ds * cc, 30));
      y = clamp32(y + floor_sh(ds * sc, 30));
      z = clamp32(z + floor_sh(ds * st, 30));
    end
    r = '{x: 32'(x), y: 32'(y), z: 32'(z), hd: 32'(hd), pt: 32'(pt),
          sp: 32'(v), lim: lim};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Driver: present the next word at the falling edge, hold it while stalled
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: predict on acceptance, check each result word
  always @(posedge clk_i) begin
    rollout_t r, e;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      roll_out(drv, r);
      expected_states.push_back(r);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_states.size() == 0) begin
        report_mismatch("unexpected word", 32'd0, 32'd0);
      end else begin
        e = expected_states.pop_front();
        if (new_x_o !== e.x) report_mismatch("new_x", new_x_o, e.x);
        if (new_y_o !== e.y) report_mismatch("new_y", new_y_o, e.y);
        if (new_z_o !== e.z) report_mismatch("new_z", new_z_o, e.z);
        if (new_heading_o !== e.hd) report_mismatch("heading", new_heading_o, e.hd);
        if (new_pitch_o !== e.pt) report_mismatch("pitch", new_pitch_o, e.pt);
        if (new_speed_o !== e.sp) report_mismatch("speed", new_speed_o, e.sp);
        if (limit_status_o !== e.lim) report_mismatch("status", 32'(limit_status_o), 32'(e.lim));
      end
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(1 << 21)) - (1 << 20));
      3: return 32'(int'($urandom_range(1 << 12)) - (1 << 11));
      default: return $urandom();
    endcase
  endfunction

  // Plausible flight word most of the time, full-range noise otherwise
  function automatic state_word_t rand_word();
    state_word_t w;
    if ($urandom_range(99) < 75) begin
      w.px = $urandom(); w.py = $urandom(); w.pz = $urandom();
      w.hd = 32'(int'($urandom_range(823550)) - 411775);
      w.pt = 32'(int'($urandom_range(205888)) - 102944);
      w.sp = 32'(int'($urandom_range(1900000)) - 100000);
      w.ac = 32'(int'($urandom_range(1310720)) - 655360);
      w.hr = 32'(int'($urandom_range(1310720)) - 655360);
      w.pr = 32'(int'($urandom_range(1310720)) - 655360);
    end else begin
      w = {pick32(), pick32(), pick32(), pick32(), pick32(), pick32(), pick32(),
           pick32(), pick32()};
    end
    return w;
  endfunction

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_STEP_COUNT: steps_q = val[7:0];
      REG_TIME_STEP:  dt_q = val[16:0];
      REG_MIN_SPEED:  vmin_q = val[30:0];
      REG_MAX_SPEED:  vmax_q = val[30:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_states.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_batch(input int count);
    for (int i = 0; i < count; i++) pending_words.push_back(rand_word());
    drain();
  endtask

  initial begin
    state_word_t w;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: extremes, zero speed, zero control, default registers
    w = '0; pending_words.push_back(w);
    w = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000};
    pending_words.push_back(w);
    pending_words.push_back(~w);
    w = '{0, 0, 0, 32'h10000, 32'h8000, 0, 32'h10000, 32'h10000, 32'hFFFF0000};
    pending_words.push_back(w);
    w = '{0, 0, 0, 0, 0, 32'hF0000, 0, 32'h50000, 32'h20000};
    pending_words.push_back(w);
    w = '{0, 0, 0, 0, 0, 32'h50000, 32'hFFFF0000, 0, 0};
    pending_words.push_back(w);
    w = '{0, 0, 0, 0, 0, 32'h180000, 32'h10000, 0, 0};
    pending_words.push_back(w);
    w = '{32'h7FFFFF00, 32'h80000100, 32'h7FFFFF00, 32'h1921F, 32'h1921F,
          32'h7FFF0000, 0, 0, 0};
    pending_words.push_back(w);
    drain();

    // Zero steps, zero dt, then the opposite extremes
    write_reg(REG_STEP_COUNT, 32'd0);
    write_reg(REG_TIME_STEP, 32'd0);
    write_reg(REG_MIN_SPEED, 32'd0);
    write_reg(REG_MAX_SPEED, 32'h7FFFFFFF);
    run_batch(4);
    write_reg(REG_STEP_COUNT, 32'd3);
    run_batch(4);
    write_reg(REG_STEP_COUNT, 32'd255);
    write_reg(REG_TIME_STEP, 32'h10000);
    write_reg(REG_MIN_SPEED, 32'h7FFFFFFF);
    write_reg(REG_MAX_SPEED, 32'd0);
    write_reg(8'd9, 32'hFFFFFFFF);
    run_batch(3);
    write_reg(REG_STEP_COUNT, 32'd1);
    write_reg(REG_TIME_STEP, 32'd1);
    run_batch(6);

    // Random: sender light, receiver heavy; then swapped; then free-running
    write_reg(REG_STEP_COUNT, 32'd4);
    write_reg(REG_TIME_STEP, 32'd3277);
    write_reg(REG_MIN_SPEED, 32'd655360);
    write_reg(REG_MAX_SPEED, 32'd1310720);
    send_idle_pct = 19; recv_idle_pct = 61;
    run_batch(280);
    write_reg(REG_STEP_COUNT, 32'd2);
    write_reg(REG_TIME_STEP, 32'($urandom_range(65536, 1)));
    write_reg(REG_MIN_SPEED, 32'($urandom_range(1 << 20)));
    write_reg(REG_MAX_SPEED, 32'($urandom_range(1 << 22)));
    send_idle_pct = 61; recv_idle_pct = 19;
    run_batch(280);
    write_reg(REG_STEP_COUNT, 32'd10);
    write_reg(REG_TIME_STEP, 32'd3277);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_batch(250);

    if (mismatches == 0) $display("PASS point_mass_kinematic_rollout");
    else $display("FAIL point_mass_kinematic_rollout");
    $finish;
  end

  // Watchdog
  initial begin
    #200000000;
    $display("FAIL point_mass_kinematic_rollout");
    $finish;
  end

endmodule
